### sv/go_back_n_sender_window_defines.svh
// Assertion macros shared by the go_back_n_sender_window checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/gbn_pkg.sv
// Shared constants and types for the Go-Back-N sender window block.
// No dependencies; used by the controller, datapath and top level.
package gbn_pkg;

	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	localparam int TOTAL_W = 16;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	// register index sits in paddr[2]
	localparam logic [0:0] REG_TOTAL_PACKETS = 1'b0;

	typedef struct packed {
		logic start_run;     // open a round
		logic send_step;     // emit one send command of the round
		logic status_start;  // start with nothing left: emit done status
		logic event_upd;     // apply ack or timeout, emit status
	} gbn_cmd_t;

	typedef struct packed {
		logic busy;      // round in progress
		logic has_left;  // acked count below total
		logic run_last;  // one send command left in the run
	} gbn_sts_t;

endpackage

### sv/gbn_req_if.sv
// Request channel: event type and acknowledgement value.
// Depends on nothing; width set by SEQ_WIDTH.
interface gbn_req_if #(
	parameter int SEQ_WIDTH = 16
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [SEQ_WIDTH-1:0] ack_value;

	modport source (output valid, req_type, ack_value, input ready);
	modport sink   (input valid, req_type, ack_value, output ready);
endinterface

### sv/gbn_res_if.sv
// Result channel: send commands and status results.
// Depends on nothing; widths set by SEQ_WIDTH and WIN_W.
interface gbn_res_if #(
	parameter int SEQ_WIDTH = 16,
	parameter int WIN_W     = 7
);
	logic                 valid;
	logic                 ready;
	logic                 send_valid;
	logic [SEQ_WIDTH-1:0] send_seq;
	logic                 last_of_run;
	logic                 transfer_done;
	logic [WIN_W-1:0]     window_now;

	modport source (output valid, send_valid, send_seq, last_of_run, transfer_done, window_now,
		input ready);
	modport sink   (input valid, send_valid, send_seq, last_of_run, transfer_done, window_now,
		output ready);
endinterface

### sv/go_back_n_sender_window.sv
// Go-Back-N sender window controller. A start event opens a round of
// min(window, packets left) send commands, one per cycle while the result
// register is not stalled, once the controller is in its send state; the
// run counter in the datapath sets that length. An ack or timeout while a
// round is open gives one status result the cycle after acceptance. A new
// event is taken only when no run is in progress and the result register is
// empty or being drained. Events that find the block in the wrong mode give
// no result. total_packets sits at byte address 0 of the APB port and resets
// to 1; write it only while idle.
// Depends on gbn_pkg, gbn_req_if, gbn_res_if, gbn_ctrl and gbn_dpath.
module go_back_n_sender_window #(
	parameter int MAX_WINDOW = 64,
	parameter int SEQ_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gbn_pkg::APB_AW-1:0]    paddr,
	input  logic [gbn_pkg::APB_DW-1:0]    pwdata,
	output logic [gbn_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	gbn_req_if.sink                       req,
	gbn_res_if.source                     res
);

	localparam int WIN_W = $clog2(MAX_WINDOW + 1);

	logic [gbn_pkg::TOTAL_W-1:0] total_q;
	logic                        reg_hit;
	gbn_pkg::gbn_cmd_t           cmd;
	gbn_pkg::gbn_sts_t           sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[gbn_pkg::APB_AW-1] == gbn_pkg::REG_TOTAL_PACKETS);
	assign prdata  = reg_hit ? gbn_pkg::APB_DW'(total_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= gbn_pkg::TOTAL_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			total_q <= pwdata[gbn_pkg::TOTAL_W-1:0];
		end
	end

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbn_dpath #(
		.MAX_WINDOW (MAX_WINDOW),
		.SEQ_WIDTH  (SEQ_WIDTH),
		.WIN_W      (WIN_W)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req.req_type),
		.ack_value     (req.ack_value),
		.total_packets (total_q),
		.cmd           (cmd),
		.sts           (sts),
		.send_valid    (res.send_valid),
		.send_seq      (res.send_seq),
		.last_of_run   (res.last_of_run),
		.transfer_done (res.transfer_done),
		.window_now    (res.window_now)
	);

endmodule

### sv/gbn_ctrl.sv
// Controller for the Go-Back-N sender: decodes events, sequences send runs,
// owns the result valid flag. Uses gbn_pkg command and status structs.
module gbn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	output logic              out_valid,
	input  logic              out_ready,
	input  gbn_pkg::gbn_sts_t sts,
	output gbn_pkg::gbn_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_SEND
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   acc;
	logic   load;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		in_ready  = (state_q == S_IDLE) && slot_free;
		acc       = in_valid && in_ready;
		cmd       = '0;
		if (acc) begin
			case (req_type)
				gbn_pkg::REQ_START: begin
					if (!sts.busy) begin
						if (sts.has_left) begin
							cmd.start_run = 1'b1;
						end else begin
							cmd.status_start = 1'b1;
						end
					end
				end
				gbn_pkg::REQ_ACK, gbn_pkg::REQ_TIMEOUT: begin
					cmd.event_upd = sts.busy;
				end
				default: ;
			endcase
		end
		cmd.send_step = (state_q == S_SEND) && slot_free;
		load = cmd.send_step || cmd.status_start || cmd.event_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start_run) state_q <= S_SEND;
				end
				S_SEND: begin
					if (cmd.send_step && sts.run_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/gbn_dpath.sv
// Datapath for the Go-Back-N sender: acked count, window, run counters and
// the result register. Driven by gbn_ctrl through gbn_pkg structs.
module gbn_dpath #(
	parameter int MAX_WINDOW = 64,
	parameter int SEQ_WIDTH  = 16,
	parameter int WIN_W      = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        req_type,
	input  logic [SEQ_WIDTH-1:0]              ack_value,
	input  logic [gbn_pkg::TOTAL_W-1:0]       total_packets,
	input  gbn_pkg::gbn_cmd_t                 cmd,
	output gbn_pkg::gbn_sts_t                 sts,
	output logic                              send_valid,
	output logic [SEQ_WIDTH-1:0]              send_seq,
	output logic                              last_of_run,
	output logic                              transfer_done,
	output logic [WIN_W-1:0]                  window_now
);

	localparam int CW = (SEQ_WIDTH > gbn_pkg::TOTAL_W) ? SEQ_WIDTH : gbn_pkg::TOTAL_W;
	localparam logic [WIN_W:0]   MAXW_X = (WIN_W+1)'(MAX_WINDOW);
	localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);

	logic [SEQ_WIDTH-1:0] acked_q;
	logic [WIN_W-1:0]     window_q;
	logic                 busy_q;
	logic [SEQ_WIDTH-1:0] last_q;
	logic [SEQ_WIDTH-1:0] seq_q;
	logic [WIN_W-1:0]     left_q;

	logic [CW-1:0]        acked_x;
	logic [CW-1:0]        total_x;
	logic [CW-1:0]        remain;
	logic [WIN_W-1:0]     run_n;
	logic [SEQ_WIDTH-1:0] expected;
	logic                 is_ack;
	logic                 match;
	logic                 higher;
	logic                 round_end;
	logic [WIN_W:0]       win_dbl;
	logic [WIN_W-1:0]     win_up;
	logic [WIN_W-1:0]     win_dn;
	logic [SEQ_WIDTH-1:0] acked_n;
	logic [WIN_W-1:0]     window_n;
	logic                 busy_n;
	logic                 done_n;

	always_comb begin
		acked_x  = CW'(acked_q);
		total_x  = CW'(total_packets);
		remain   = total_x - acked_x;
		run_n    = (CW'(window_q) < remain) ? window_q : remain[WIN_W-1:0];
		expected = acked_q + SEQ_WIDTH'(1);
		is_ack   = (req_type == gbn_pkg::REQ_ACK);
		match    = is_ack && (ack_value == expected);
		higher   = is_ack && (ack_value > expected);
		round_end = (expected == last_q);
		win_dbl  = {window_q, 1'b0};
		win_up   = (win_dbl > MAXW_X) ? MAXW_X[WIN_W-1:0] : win_dbl[WIN_W-1:0];
		win_dn   = (window_q > WIN_ONE) ? window_q - WIN_ONE : WIN_ONE;
		if (match) begin
			acked_n  = expected;
			window_n = round_end ? win_up : window_q;
			busy_n   = !round_end;
		end else begin
			if (higher) begin
				acked_n = (ack_value < last_q) ? ack_value : last_q;
			end else begin
				acked_n = acked_q;
			end
			window_n = win_dn;
			busy_n   = 1'b0;
		end
		done_n = CW'(acked_n) >= total_x;

		sts.busy     = busy_q;
		sts.has_left = acked_x < total_x;
		sts.run_last = (left_q == WIN_ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q  <= '0;
			window_q <= WIN_ONE;
			busy_q   <= 1'b0;
		end else begin
			if (cmd.start_run) busy_q <= 1'b1;
			if (cmd.event_upd) begin
				acked_q  <= acked_n;
				window_q <= window_n;
				busy_q   <= busy_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_run) begin
			last_q <= acked_q + SEQ_WIDTH'(run_n);
			seq_q  <= expected;
			left_q <= run_n;
		end
		if (cmd.send_step) begin
			send_valid    <= 1'b1;
			send_seq      <= seq_q;
			last_of_run   <= (left_q == WIN_ONE);
			transfer_done <= 1'b0;
			window_now    <= window_q;
			seq_q         <= seq_q + SEQ_WIDTH'(1);
			left_q        <= left_q - WIN_ONE;
		end
		if (cmd.status_start) begin
			send_valid    <= 1'b0;
			send_seq      <= acked_q;
			last_of_run   <= 1'b1;
			transfer_done <= 1'b1;
			window_now    <= window_q;
		end
		if (cmd.event_upd) begin
			send_valid    <= 1'b0;
			send_seq      <= acked_n;
			last_of_run   <= 1'b1;
			transfer_done <= done_n;
			window_now    <= window_n;
		end
	end

endmodule

### sv/gbn_checker.sv
// Port-level checks for go_back_n_sender_window, bound to the top level.
// Depends on go_back_n_sender_window_defines.svh for the assertion macros.
`include "go_back_n_sender_window_defines.svh"

module gbn_checker #(
	parameter int SEQ_WIDTH = 16,
	parameter int WIN_W     = 7
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 send_valid,
	input logic [SEQ_WIDTH-1:0] send_seq,
	input logic                 last_of_run,
	input logic                 transfer_done,
	input logic [WIN_W-1:0]     window_now
);

	`GBN_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(send_seq) && $stable(send_valid) && $stable(window_now), "stalled result changed")
	`GBN_ASSERT_NOW(a_status_last, res_valid && !send_valid, last_of_run, "status result without last_of_run")
	`GBN_ASSERT_NOW(a_send_not_done, res_valid && send_valid, !transfer_done, "send command flagged done")
	`GBN_ASSERT_NOW(a_run_blocks_req, res_valid && send_valid && !last_of_run, !(req_valid && req_ready), "event taken inside a send run")

endmodule

bind go_back_n_sender_window gbn_checker #(
	.SEQ_WIDTH (SEQ_WIDTH),
	.WIN_W     (WIN_W)
) u_gbn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.send_valid    (res.send_valid),
	.send_seq      (res.send_seq),
	.last_of_run   (res.last_of_run),
	.transfer_done (res.transfer_done),
	.window_now    (res.window_now)
);

### test/tb.sv
// Testbench for go_back_n_sender_window: drives start, ack and timeout events plus APB
// writes, predicts every send command and status result, and checks them in order.
// Depends on gbn_pkg, gbn_req_if, gbn_res_if and the go_back_n_sender_window RTL.
module tb;

	localparam int         MAX_WIN    = 64;
	localparam int         SEQ_W      = 16;
	localparam int         WIN_W      = 7;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int         SETTLE     = 8;

	typedef struct packed {
		logic             send_valid;
		logic [SEQ_W-1:0] send_seq;
		logic             last_of_run;
		logic             transfer_done;
		logic [WIN_W-1:0] window_now;
	} gbn_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [gbn_pkg::APB_AW-1:0] paddr;
	logic [gbn_pkg::APB_DW-1:0] pwdata;
	logic [gbn_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	gbn_req_if #(.SEQ_WIDTH(SEQ_W)) req_if ();
	gbn_res_if #(.SEQ_WIDTH(SEQ_W), .WIN_W(WIN_W)) res_if ();

	go_back_n_sender_window #(.MAX_WINDOW(MAX_WIN), .SEQ_WIDTH(SEQ_W)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.res     (res_if)
	);

	// predicted sender state
	logic [SEQ_W-1:0] total_pkts;
	logic [SEQ_W-1:0] acked;
	logic [WIN_W-1:0] win;
	logic [WIN_W-1:0] round_len;
	logic [WIN_W-1:0] round_acked;
	logic             in_round;

	gbn_result_t owed_q[$];
	int          mismatches;
	int          answered_items;
	int          rx_hold_len;
	bit          gaps_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic int predict_window_event(logic [1:0] kind, logic [SEQ_W-1:0] ack);
		logic [SEQ_W:0] next_seq;
		logic [SEQ_W:0] last_sent;
		logic [WIN_W:0] doubled;
		int             n;
		case (kind)
			gbn_pkg::REQ_START: begin
				if (in_round)
					return 0;
				if (acked >= total_pkts) begin
					owed_q.push_back('{1'b0, acked, 1'b1, 1'b1, win});
					return 1;
				end
				n = (win < total_pkts - acked) ? int'(win) : int'(total_pkts - acked);
				round_len   = n[WIN_W-1:0];
				round_acked = '0;
				in_round    = 1'b1;
				for (int k = 0; k < n; k++)
					owed_q.push_back('{1'b1, acked + SEQ_W'(k + 1), k == n - 1, 1'b0, win});
				return n;
			end
			gbn_pkg::REQ_ACK, gbn_pkg::REQ_TIMEOUT: begin
				if (!in_round)
					return 0;
				next_seq  = {1'b0, acked} + 1'b1;
				last_sent = {1'b0, acked} + (SEQ_W + 1)'(round_len - round_acked);
				if (kind == gbn_pkg::REQ_ACK && {1'b0, ack} == next_seq) begin
					acked       = next_seq[SEQ_W-1:0];
					round_acked = round_acked + 1'b1;
					if (round_acked >= round_len) begin
						in_round = 1'b0;
						doubled  = {win, 1'b0};
						win      = (doubled > MAX_WIN) ? WIN_W'(MAX_WIN) : doubled[WIN_W-1:0];
					end
				end else begin
					if (kind == gbn_pkg::REQ_ACK && {1'b0, ack} > next_seq)
						acked = ({1'b0, ack} < last_sent) ? ack : last_sent[SEQ_W-1:0];
					in_round = 1'b0;
					win      = (win > 1) ? win - 1'b1 : WIN_W'(1);
				end
				owed_q.push_back('{1'b0, acked, 1'b1, acked >= total_pkts, win});
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic send_event(input logic [1:0] kind, input logic [SEQ_W-1:0] ack);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= kind;
		req_if.ack_value <= ack;
		do @(posedge clk); while (!req_if.ready);
		if (predict_window_event(kind, ack) > 0)
			answered_items++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// closes any open round first so the write lands while the block is idle
	task automatic set_total_packets(input logic [SEQ_W-1:0] value);
		if (in_round)
			send_event(gbn_pkg::REQ_TIMEOUT, '0);
		wait_results_drained();
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {gbn_pkg::REG_TOTAL_PACKETS, 2'b00};
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		total_pkts = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'd0, value})
			flag_mismatch($sformatf("total_packets read back %0d, wrote %0d", prdata, value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly starts or in-order acks; of every err_odds events about three (idle) or six (in a round) are faults or noise
	task automatic random_event(input int err_odds);
		int pick;
		pick = $urandom_range(0, err_odds - 1);
		if (!in_round) begin
			case (pick)
				0:       send_event(gbn_pkg::REQ_ACK, SEQ_W'($urandom));
				1:       send_event(REQ_UNUSED, SEQ_W'($urandom));
				2:       send_event(gbn_pkg::REQ_TIMEOUT, SEQ_W'($urandom));
				default: send_event(gbn_pkg::REQ_START, SEQ_W'($urandom));
			endcase
		end else begin
			case (pick)
				0:       send_event(gbn_pkg::REQ_TIMEOUT, SEQ_W'($urandom));
				1:       send_event(gbn_pkg::REQ_ACK,
						acked + 2'd2 + SEQ_W'($urandom_range(0, win + 3)));
				2:       send_event(gbn_pkg::REQ_ACK, SEQ_W'($urandom_range(0, acked)));
				3:       send_event(gbn_pkg::REQ_ACK, SEQ_W'($urandom));
				4:       send_event(gbn_pkg::REQ_START, SEQ_W'($urandom));
				5:       send_event(REQ_UNUSED, SEQ_W'($urandom));
				default: send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
			endcase
		end
	endtask

	task automatic run_random(input int n_items, input int err_odds);
		int target;
		target = answered_items + n_items;
		while (answered_items < target) begin
			random_event(err_odds);
			if ($urandom_range(0, 39) == 0)
				wait_results_drained();
		end
	endtask

	// reset total of 1: idle events, busy start, window floor, clamp of a high ack
	task automatic test_single_packet_transfer();
		send_event(gbn_pkg::REQ_ACK, 16'h00FF);
		send_event(gbn_pkg::REQ_TIMEOUT, '0);
		send_event(REQ_UNUSED, 16'hFFFF);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_TIMEOUT, '0);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_ACK, 16'h0000);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_ACK, 16'hFFFF);
		send_event(gbn_pkg::REQ_START, '0);
	endtask

	task automatic test_window_growth_and_repair();
		set_total_packets(16'hFFFF);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
		send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
		send_event(gbn_pkg::REQ_START, '0);
		send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
		send_event(gbn_pkg::REQ_ACK, acked + 2'd2);
	endtask

	task automatic test_receiver_stall();
		wait_results_drained();
		rx_hold_len = 300;
		repeat (3) begin
			send_event(gbn_pkg::REQ_START, '0);
			while (in_round)
				send_event(gbn_pkg::REQ_ACK, acked + 1'b1);
		end
		wait_results_drained();
	endtask

	task automatic test_random_rounds();
		run_random(40, 40);
		set_total_packets(acked + 16'd12);
		run_random(15, 20);
		set_total_packets(16'd1);
		run_random(5, 20);
		set_total_packets(acked + SEQ_W'($urandom_range(30, 300)));
		run_random(20, 25);
		gaps_on = 1'b0;
		set_total_packets(16'hFFFF);
		run_random(35, 40);
		wait_results_drained();
	endtask

	always @(posedge clk) begin : check_results
		gbn_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (owed_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result valid %0b seq %0d",
					res_if.send_valid, res_if.send_seq));
			end else begin
				want = owed_q.pop_front();
				if (res_if.send_valid !== want.send_valid || res_if.send_seq !== want.send_seq
						|| res_if.last_of_run !== want.last_of_run
						|| res_if.transfer_done !== want.transfer_done
						|| res_if.window_now !== want.window_now)
					flag_mismatch($sformatf(
						"expected v%0b seq %0d last %0b done %0b win %0d, got v%0b seq %0d last %0b done %0b win %0d",
						want.send_valid, want.send_seq, want.last_of_run, want.transfer_done,
						want.window_now, res_if.send_valid, res_if.send_seq, res_if.last_of_run,
						res_if.transfer_done, res_if.window_now));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				res_if.ready <= 1'b0;
				repeat (rx_hold_len - 1) @(negedge clk);
				rx_hold_len = 0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_if.valid     = 1'b0;
		req_if.req_type  = gbn_pkg::REQ_START;
		req_if.ack_value = '0;
		total_pkts       = gbn_pkg::TOTAL_RESET;
		acked            = '0;
		win              = WIN_W'(1);
		round_len        = '0;
		round_acked      = '0;
		in_round         = 1'b0;
		mismatches       = 0;
		answered_items   = 0;
		rx_hold_len      = 0;
		gaps_on          = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_packet_transfer();
		test_window_growth_and_repair();
		test_receiver_stall();
		test_random_rounds();

		repeat (20) @(posedge clk);
		if (owed_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", owed_q.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### sim.f
+incdir+sv
sv/gbn_pkg.sv
sv/gbn_req_if.sv
sv/gbn_res_if.sv
sv/gbn_ctrl.sv
sv/gbn_dpath.sv
sv/go_back_n_sender_window.sv
sv/gbn_checker.sv
test/tb.sv
